FILE: sv/knsl_pkg.sv
// Shared types, codes and constants of the k-nearest sorted list unit.
package knsl_pkg;

  localparam int SLOTS     = 16;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int DIST_BITS = 32;
  localparam int ID_BITS   = 32;
  localparam int CFG_W     = 7;
  localparam int IDX_W     = 2;

  localparam logic signed [DIST_BITS-1:0] DIST_MAX = {1'b0, {(DIST_BITS-1){1'b1}}};
  localparam logic [CFG_W-1:0] ZERO_SAT = 7'd127;
  localparam logic [CFG_W-1:0] DEF_ACTIVE_COUNT = 7'd16;

  // Action codes of an input item.
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DUMP   = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_ACTIVE_COUNT = 2'd0;
  localparam logic [IDX_W-1:0] REG_NEG_ALLOWED  = 2'd1;
  localparam logic [IDX_W-1:0] REG_ZERO_GOAL    = 2'd2;

  typedef struct packed {
    logic [1:0]                  action;
    logic [ID_BITS-1:0]          neighbour_id;
    logic signed [DIST_BITS-1:0] distance;
  } in_item_t;

  typedef struct packed {
    logic [ID_BITS-1:0]          entry_id;
    logic signed [DIST_BITS-1:0] entry_distance;
    logic                        entry_valid;
    logic                        inserted;
    logic                        negative_error;
    logic                        zero_goal_reached;
    logic                        last;
  } res_item_t;

  // Classified command passed from the front to the back.
  typedef struct packed {
    logic [1:0]                  kind;
    logic [ID_BITS-1:0]          id;
    logic signed [DIST_BITS-1:0] distance;
    logic                        is_zero;
    logic                        neg_refused;
  } cmd_t;

  // Configuration seen by the back.
  typedef struct packed {
    logic [SLOT_W-1:0] last_slot;
    logic [CFG_W-1:0]  zero_goal;
    logic              list_reset;
  } back_cfg_t;

endpackage

FILE: sv/knsl_front.sv
// Front end: accepts items and classifies them into queue commands.
module knsl_front (
  input  logic               start,
  input  logic               full,
  input  knsl_pkg::in_item_t item,
  input  logic               negatives_allowed,
  output logic               push,
  output knsl_pkg::cmd_t     cmd
);
  import knsl_pkg::*;

  logic known;

  // The unused action code is dropped here and never reaches the queue.
  assign known = (item.action == ACT_INSERT) || (item.action == ACT_DUMP) ||
                 (item.action == ACT_CLEAR);
  assign push  = start && !full && known;

  always_comb begin
    cmd.kind        = item.action;
    cmd.id          = item.neighbour_id;
    cmd.distance    = item.distance;
    cmd.is_zero     = (item.distance == '0);
    cmd.neg_refused = item.distance[DIST_BITS-1] && !negatives_allowed;
  end

endmodule

FILE: sv/knsl_queue.sv
// Two-entry command queue between the front and the back.
module knsl_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  knsl_pkg::cmd_t push_cmd,
  input  logic           pop,
  output knsl_pkg::cmd_t head,
  output logic           full,
  output logic           empty
);
  import knsl_pkg::*;

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

FILE: sv/knsl_back.sv
// Back end: compare-and-shift slot cells, dump sequencer and result register.
module knsl_back (
  input  logic                clk,
  input  logic                rst,
  input  knsl_pkg::back_cfg_t cfg,
  input  logic                have_cmd,
  input  knsl_pkg::cmd_t      cmd,
  output logic                pop,
  output knsl_pkg::res_item_t result,
  output logic                result_valid
);
  import knsl_pkg::*;

  logic signed [DIST_BITS-1:0] slot_distance [SLOTS];
  logic [ID_BITS-1:0]          slot_id       [SLOTS];
  logic [SLOTS-1:0]            slot_valid;

  logic signed [DIST_BITS-1:0] dist_next  [SLOTS];
  logic [ID_BITS-1:0]          id_next    [SLOTS];
  logic [SLOTS-1:0]            valid_next;

  logic [SLOTS-1:0] ge;
  logic [SLOTS-1:0] gt;
  logic             ins_ok;
  logic             dumping;
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] rd_idx;
  logic [CFG_W-1:0]  zero_count;
  logic [CFG_W-1:0]  zero_inc;
  logic              goal_hit;

  assign pop = have_cmd && !dumping;

  // Each cell compares its own slot against the candidate; the sorted order
  // makes ge a run of ones above the insertion point.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      ge[i] = (slot_distance[i] >= cmd.distance);
      gt[i] = (slot_distance[i] > cmd.distance);
    end
  end

  assign ins_ok = !cmd.neg_refused && gt[cfg.last_slot];

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      dist_next[i]  = slot_distance[i];
      id_next[i]    = slot_id[i];
      valid_next[i] = slot_valid[i];
      if (SLOT_W'(i) <= cfg.last_slot && ge[i]) begin
        if (i == 0 || !ge[(i == 0) ? 0 : i - 1]) begin
          dist_next[i]  = cmd.distance;
          id_next[i]    = cmd.id;
          valid_next[i] = 1'b1;
        end else begin
          dist_next[i]  = slot_distance[(i == 0) ? 0 : i - 1];
          id_next[i]    = slot_id[(i == 0) ? 0 : i - 1];
          valid_next[i] = slot_valid[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  assign zero_inc = zero_count + 7'd1;
  assign goal_hit = cmd.is_zero && (zero_count != ZERO_SAT) &&
                    (cfg.zero_goal != '0) && (zero_inc == cfg.zero_goal);
  assign rd_idx   = dumping ? idx : '0;

  always_ff @(posedge clk) begin
    if (rst || cfg.list_reset || (pop && cmd.kind == ACT_CLEAR)) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_distance[i] <= DIST_MAX;
        slot_id[i]       <= '0;
      end
      slot_valid <= '0;
    end else if (pop && cmd.kind == ACT_INSERT && ins_ok) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_distance[i] <= dist_next[i];
        slot_id[i]       <= id_next[i];
      end
      slot_valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dumping      <= 1'b0;
      idx          <= '0;
      zero_count   <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (dumping) begin
        result_valid <= 1'b1;
        if (idx == cfg.last_slot) begin
          dumping <= 1'b0;
        end else begin
          idx <= SLOT_W'(idx + 1'b1);
        end
      end else if (pop) begin
        unique case (cmd.kind)
          ACT_INSERT: begin
            result_valid <= 1'b1;
            if (cmd.is_zero && zero_count != ZERO_SAT) begin
              zero_count <= zero_inc;
            end
          end
          ACT_DUMP: begin
            result_valid <= 1'b1;
            if (cfg.last_slot != '0) begin
              dumping <= 1'b1;
              idx     <= SLOT_W'(1);
            end
          end
          ACT_CLEAR: begin
            zero_count <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result payload; only meaningful while result_valid is high.
  always_ff @(posedge clk) begin
    if (dumping || (pop && cmd.kind == ACT_DUMP)) begin
      result.entry_id          <= slot_id[rd_idx];
      result.entry_distance    <= slot_distance[rd_idx];
      result.entry_valid       <= slot_valid[rd_idx];
      result.inserted          <= 1'b0;
      result.negative_error    <= 1'b0;
      result.zero_goal_reached <= 1'b0;
      result.last              <= (rd_idx == cfg.last_slot);
    end else if (pop && cmd.kind == ACT_INSERT) begin
      result.entry_id          <= cmd.id;
      result.entry_distance    <= cmd.distance;
      result.entry_valid       <= 1'b0;
      result.inserted          <= ins_ok;
      result.negative_error    <= cmd.neg_refused;
      result.zero_goal_reached <= goal_hit;
      result.last              <= 1'b1;
    end
  end

endmodule

FILE: sv/k_nearest_sorted_list_unit.sv
// Top level of the k-nearest sorted list unit: configuration registers and wiring.
// An insert passes the queue and the back's result register before its result strobes.
// Throughput: inserts and clears one per cycle unless a dump runs; a dump emits K results,
// during which the back holds, so the two-entry queue can fill and busy rise.
// Reset: the list is emptied, the zero count cleared and the registers take their defaults.
// The receiver cannot stall: each result is on the ports for exactly one cycle.
module k_nearest_sorted_list_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  knsl_pkg::in_item_t         item,
  output knsl_pkg::res_item_t        result,
  output logic                       result_valid,
  input  logic                       cfg_write,
  input  logic [knsl_pkg::IDX_W-1:0] cfg_index,
  input  logic [knsl_pkg::CFG_W-1:0] cfg_data
);
  import knsl_pkg::*;

  logic [CFG_W-1:0] active_count;
  logic             negatives_allowed;
  logic [CFG_W-1:0] zero_goal;
  back_cfg_t        bcfg;

  logic push;
  logic pop;
  logic full;
  logic empty;
  cmd_t push_cmd;
  cmd_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_count      <= DEF_ACTIVE_COUNT;
      negatives_allowed <= 1'b0;
      zero_goal         <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ACTIVE_COUNT: active_count      <= cfg_data;
        REG_NEG_ALLOWED:  negatives_allowed <= cfg_data[0];
        REG_ZERO_GOAL:    zero_goal         <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // A count of zero behaves as one, and counts above the slot total as the total.
  always_comb begin
    if (active_count == '0) begin
      bcfg.last_slot = '0;
    end else if (active_count > CFG_W'(SLOTS)) begin
      bcfg.last_slot = SLOT_W'(SLOTS - 1);
    end else begin
      bcfg.last_slot = SLOT_W'(active_count - 7'd1);
    end
    bcfg.zero_goal  = zero_goal;
    bcfg.list_reset = cfg_write && (cfg_index == REG_ACTIVE_COUNT);
  end

  assign busy = full;

  knsl_front u_front (
    .start             (start),
    .full              (full),
    .item              (item),
    .negatives_allowed (negatives_allowed),
    .push              (push),
    .cmd               (push_cmd)
  );

  knsl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  knsl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (bcfg),
    .have_cmd     (!empty),
    .cmd          (head),
    .pop          (pop),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

FILE: sim/knsl_checker.sv
// Checker for the k-nearest sorted list unit: mirrors the list, predicts each result and compares.
`timescale 1ns / 1ps
module knsl_checker
  import knsl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  in_item_t         item,
  input  res_item_t        result,
  input  logic             result_valid,
  input  logic             cfg_write,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               fail_count,
  output int               pending
);

  localparam int REPORT_MAX = 10;

  // Shadow copy of the configuration and of the neighbour list.
  logic [CFG_W-1:0]            keep_count;
  logic                        neg_ok;
  logic [CFG_W-1:0]            goal_count;
  logic [CFG_W-1:0]            zero_count;
  logic signed [DIST_BITS-1:0] nn_dist [SLOTS];
  logic [ID_BITS-1:0]          nn_id [SLOTS];
  logic                        nn_valid [SLOTS];

  res_item_t expected_entries [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic int slots_in_use();
    if (keep_count == 0) return 1;
    if (keep_count > SLOTS) return SLOTS;
    return int'(keep_count);
  endfunction

  function automatic string show(res_item_t r);
    return $sformatf("id=%h dist=%h valid=%b ins=%b neg=%b goal=%b last=%b",
                     r.entry_id, r.entry_distance, r.entry_valid, r.inserted,
                     r.negative_error, r.zero_goal_reached, r.last);
  endfunction

  task automatic empty_list();
    for (int i = 0; i < SLOTS; i++) begin
      nn_dist[i] = DIST_MAX;
      nn_id[i] = '0;
      nn_valid[i] = 1'b0;
    end
  endtask

  task automatic note_failure(string what, string detail);
    if (fail_count < REPORT_MAX) begin
      $display("%0t: %s: %s", $realtime, what, detail);
    end
    fail_count++;
  endtask

  task automatic write_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      REG_ACTIVE_COUNT: begin
        keep_count = data;
        empty_list();
      end
      REG_NEG_ALLOWED: begin
        neg_ok = data[0];
      end
      REG_ZERO_GOAL: begin
        goal_count = data;
      end
      default: begin
      end
    endcase
  endtask

  // Updates the shadow list for one accepted item and queues the results it causes.
  task automatic advance_neighbour_list(in_item_t it);
    int k;
    int pos;
    logic signed [DIST_BITS-1:0] d;
    res_item_t r;
    k = slots_in_use();
    d = it.distance;
    r = '0;
    case (it.action)
      ACT_INSERT: begin
        if (d == 0) begin
          // The zero count moves even when the candidate is then rejected.
          if (zero_count < ZERO_SAT) begin
            zero_count++;
            if (goal_count != 0 && zero_count == goal_count) r.zero_goal_reached = 1'b1;
          end
        end else if (d < 0 && !neg_ok) begin
          r.negative_error = 1'b1;
        end
        if (!r.negative_error && d < nn_dist[k-1]) begin
          pos = 0;
          while (pos < k - 1 && nn_dist[pos] < d) pos++;
          for (int i = k - 1; i > pos; i--) begin
            nn_dist[i] = nn_dist[i-1];
            nn_id[i] = nn_id[i-1];
            nn_valid[i] = nn_valid[i-1];
          end
          nn_dist[pos] = d;
          nn_id[pos] = it.neighbour_id;
          nn_valid[pos] = 1'b1;
          r.inserted = 1'b1;
        end
        r.entry_id = it.neighbour_id;
        r.entry_distance = d;
        r.last = 1'b1;
        expected_entries.push_back(r);
      end
      ACT_DUMP: begin
        for (int i = 0; i < k; i++) begin
          r = '0;
          r.entry_id = nn_id[i];
          r.entry_distance = nn_dist[i];
          r.entry_valid = nn_valid[i];
          r.last = (i == k - 1);
          expected_entries.push_back(r);
        end
      end
      ACT_CLEAR: begin
        empty_list();
        zero_count = '0;
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    res_item_t exp_r;
    if (rst) begin
      keep_count = DEF_ACTIVE_COUNT;
      neg_ok = 1'b0;
      goal_count = '0;
      zero_count = '0;
      empty_list();
      expected_entries.delete();
    end else begin
      if (result_valid === 1'b1) begin
        if (expected_entries.size() == 0) begin
          note_failure("unexpected result", show(result));
        end else begin
          exp_r = expected_entries.pop_front();
          if (result.entry_id !== exp_r.entry_id ||
              result.entry_distance !== exp_r.entry_distance ||
              result.entry_valid !== exp_r.entry_valid ||
              result.inserted !== exp_r.inserted ||
              result.negative_error !== exp_r.negative_error ||
              result.zero_goal_reached !== exp_r.zero_goal_reached ||
              result.last !== exp_r.last) begin
            note_failure("result mismatch",
                         {"expected ", show(exp_r), " got ", show(result)});
          end
        end
      end
      if (cfg_write === 1'b1) write_register(cfg_index, cfg_data);
      if (start === 1'b1 && busy === 1'b0) advance_neighbour_list(item);
    end
    pending = expected_entries.size();
  end

endmodule

FILE: sim/tb.sv
// Testbench top for the k-nearest sorted list unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
  import knsl_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic signed [DIST_BITS-1:0] DIST_MIN = {1'b1, {(DIST_BITS-1){1'b0}}};
  localparam int Q_ONE = 1 << 16;

  typedef enum int {GAPS_NONE, GAPS_HEAVY, GAPS_LIGHT} gap_mode_t;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  in_item_t         item;
  res_item_t        result;
  logic             result_valid;
  logic             cfg_write;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int               fail_count;
  int               pending;
  gap_mode_t        gap_mode;

  k_nearest_sorted_list_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result       (result),
    .result_valid (result_valid),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  knsl_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result       (result),
    .result_valid (result_valid),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic in_item_t make_item(logic [1:0] act, logic [ID_BITS-1:0] id,
                                         logic signed [DIST_BITS-1:0] d);
    in_item_t it;
    it.action = act;
    it.neighbour_id = id;
    it.distance = d;
    return it;
  endfunction

  // Mostly small, clustered distances so that ties and reordering happen often.
  function automatic logic signed [DIST_BITS-1:0] random_distance();
    int unsigned r;
    logic signed [DIST_BITS-1:0] d;
    r = $urandom_range(0, 99);
    if (r < 25) d = $urandom_range(0, 15) * 4096;
    else if (r < 38) d = '0;
    else if (r < 55) d = -int'($urandom_range(1, 65536));
    else if (r < 85) d = $urandom;
    else if (r < 90) d = DIST_MAX;
    else if (r < 95) d = DIST_MIN;
    else d = '1;
    return d;
  endfunction

  function automatic in_item_t random_item(bit zero_heavy);
    in_item_t it;
    int unsigned r;
    it.neighbour_id = $urandom;
    it.distance = random_distance();
    r = $urandom_range(0, 99);
    if (zero_heavy) begin
      it.action = (r < 96) ? ACT_INSERT : ACT_DUMP;
      if ($urandom_range(0, 99) < 96) it.distance = '0;
    end else if (r < 70) begin
      it.action = ACT_INSERT;
    end else if (r < 85) begin
      it.action = ACT_DUMP;
    end else if (r < 93) begin
      it.action = ACT_CLEAR;
    end else begin
      it.action = ACT_UNUSED;
    end
    return it;
  endfunction

  // Holds start until the transfer happens, then idles for a while if the mode says so.
  task automatic send_item(in_item_t it);
    int gap;
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
    gap = 0;
    case (gap_mode)
      GAPS_HEAVY: if ($urandom_range(0, 99) < 64) gap = $urandom_range(1, 4);
      GAPS_LIGHT: if ($urandom_range(0, 99) < 14) gap = $urandom_range(1, 6);
      default: gap = 0;
    endcase
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // A clear gives no result, so the block is also left idle for a settling pause after the last one.
  task automatic settle();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure(logic [CFG_W-1:0] keep, logic allow_neg, logic [CFG_W-1:0] goal);
    cfg_write <= 1'b1;
    cfg_index <= REG_ACTIVE_COUNT;
    cfg_data <= keep;
    @(negedge clk);
    cfg_index <= REG_NEG_ALLOWED;
    cfg_data <= (CFG_W'($urandom) & ~CFG_W'(1)) | CFG_W'(allow_neg);
    @(negedge clk);
    cfg_index <= REG_SPARE;
    cfg_data <= CFG_W'($urandom);
    @(negedge clk);
    cfg_index <= REG_ZERO_GOAL;
    cfg_data <= goal;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic run_phase(logic [CFG_W-1:0] keep, logic allow_neg, logic [CFG_W-1:0] goal,
                           int count, gap_mode_t mode, bit zero_heavy);
    int sent;
    in_item_t it;
    settle();
    configure(keep, allow_neg, goal);
    gap_mode = mode;
    sent = 0;
    while (sent < count) begin
      it = random_item(zero_heavy);
      send_item(it);
      if (it.action != ACT_UNUSED) sent++;
    end
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    gap_mode = GAPS_NONE;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: zero goal, refused negatives, maximum distance, ties, dumps and clears.
    configure(7'd4, 1'b0, 7'd2);
    send_item(make_item(ACT_INSERT, 32'h0000_0000, '0));
    send_item(make_item(ACT_INSERT, 32'hFFFF_FFFF, '0));
    send_item(make_item(ACT_INSERT, 32'h0000_0011, DIST_MIN));
    send_item(make_item(ACT_INSERT, 32'h0000_0022, '1));
    send_item(make_item(ACT_INSERT, 32'h0000_0033, DIST_MAX));
    send_item(make_item(ACT_INSERT, 32'hA5A5_0001, 5 * Q_ONE));
    send_item(make_item(ACT_INSERT, 32'hA5A5_0002, 3 * Q_ONE));
    send_item(make_item(ACT_INSERT, 32'hA5A5_0003, 3 * Q_ONE));
    send_item(make_item(ACT_DUMP, '0, '0));
    send_item(make_item(ACT_INSERT, 32'hA5A5_0004, 7 * Q_ONE));
    send_item(make_item(ACT_INSERT, 32'hA5A5_0005, 1));
    send_item(make_item(ACT_DUMP, 32'hFFFF_FFFF, '1));
    send_item(make_item(ACT_UNUSED, 32'h1234_5678, 9));
    send_item(make_item(ACT_CLEAR, '0, '0));
    send_item(make_item(ACT_DUMP, '0, '0));
    settle();
    configure(7'd1, 1'b1, 7'd1);
    send_item(make_item(ACT_INSERT, 32'hC3C3_0001, DIST_MAX));
    send_item(make_item(ACT_INSERT, 32'hC3C3_0002, DIST_MIN));
    send_item(make_item(ACT_INSERT, 32'hC3C3_0003, '0));
    send_item(make_item(ACT_INSERT, 32'hC3C3_0004, '1));
    send_item(make_item(ACT_DUMP, '0, '0));

    // Random phases; the long zero-heavy one drives the zero count into saturation.
    run_phase(7'd16, 1'b0, 7'd3, 35, GAPS_NONE, 1'b0);
    run_phase(7'd5, 1'b1, 7'd10, 35, GAPS_HEAVY, 1'b0);
    run_phase(7'd127, 1'b1, 7'd0, 30, GAPS_LIGHT, 1'b0);
    run_phase(7'd1, 1'b0, 7'd64, 20, GAPS_NONE, 1'b0);
    run_phase(7'd0, 1'b1, 7'd2, 20, GAPS_HEAVY, 1'b0);
    run_phase(7'd17, 1'b1, 7'd127, 160, GAPS_LIGHT, 1'b1);
    run_phase(7'd64, 1'b0, CFG_W'($urandom_range(1, 64)), 25, GAPS_HEAVY, 1'b0);

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
